// File: rtl/core/tlt_pkg.sv
package tlt_pkg;

    localparam int MAX_TRACKS  = 64;
    localparam int SLOT_W      = $clog2(MAX_TRACKS);
    localparam int CNT_W       = $clog2(MAX_TRACKS + 1);
    localparam int COUNT_WIDTH = 16;
    localparam int ID_W        = 31;
    localparam int INV_W       = 8;
    localparam int RATIO_W     = 9;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int STATUS_W    = 2;

    localparam logic [CNT_W-1:0]       MAX_TRACKS_C = CNT_W'(MAX_TRACKS);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = '1;
    localparam logic [INV_W-1:0]       INV_MAX      = '1;
    localparam logic [RATIO_W-1:0]     RATIO_RESET  = RATIO_W'(154);
    localparam logic [INV_W-1:0]       INV_RUN_RESET = INV_W'(1);

    typedef enum logic [1:0] {
        FUNC_CREATE,
        FUNC_HIT,
        FUNC_MISS,
        FUNC_SWEEP
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_FULL,
        ST_NO_SLOT
    } t_status;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_RATIO_MIN,
        CFG_INVIS_MAX
    } t_cfg_addr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_FIN,
        S_SWEEP,
        S_SWEEP_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_slot;
        logic upd_load;
        logic fin_load;
        logic sweep_start;
        logic sweep_run;
        logic sweep_load;
    } t_cmd;

    typedef struct packed {
        logic slot_ok;
        logic out_free;
        logic sweep_done;
    } t_stat;

    typedef struct packed {
        logic [ID_W-1:0]        id;
        logic [COUNT_WIDTH-1:0] age;
        logic [COUNT_WIDTH-1:0] vis;
        logic [INV_W-1:0]       inv;
    } t_entry;

endpackage

// File: rtl/core/tlt_ctrl.sv
module tlt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tlt_pkg::t_func i_func,
    input  tlt_pkg::t_stat i_stat,
    output tlt_pkg::t_cmd  o_cmd,
    output logic           o_stall
);
    import tlt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_func)
                        FUNC_CREATE: n_state = S_FIN;
                        FUNC_HIT,
                        FUNC_MISS:   n_state = i_stat.slot_ok ? S_UPD : S_FIN;
                        FUNC_SWEEP:  n_state = S_SWEEP;
                        default:     n_state = S_FIN;
                    endcase
                end
            end
            S_UPD: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_FIN: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_SWEEP: begin
                if (i_stat.sweep_done) n_state = S_SWEEP_OUT;
            end
            S_SWEEP_OUT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall           = 1'b0;
                o_cmd.accept      = i_valid;
                o_cmd.rd_slot     = i_valid && i_stat.slot_ok &&
                                    (i_func == FUNC_HIT || i_func == FUNC_MISS);
                o_cmd.sweep_start = i_valid && (i_func == FUNC_SWEEP);
            end
            S_UPD:       o_cmd.upd_load   = i_stat.out_free;
            S_FIN:       o_cmd.fin_load   = i_stat.out_free;
            S_SWEEP:     o_cmd.sweep_run  = 1'b1;
            S_SWEEP_OUT: o_cmd.sweep_load = i_stat.out_free;
            default:     o_cmd = '0;
        endcase
    end

endmodule

// File: rtl/core/tlt_dpath.sv
module tlt_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tlt_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [tlt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  tlt_pkg::t_func                      i_func,
    input  logic [tlt_pkg::SLOT_W-1:0]          i_slot,
    input  tlt_pkg::t_cmd                       i_cmd,
    input  logic                                i_stall,
    output tlt_pkg::t_stat                      o_stat,
    output logic                                o_valid,
    output logic [tlt_pkg::STATUS_W-1:0]        o_status,
    output logic [tlt_pkg::ID_W-1:0]            o_track_id,
    output logic [tlt_pkg::SLOT_W-1:0]          o_slot_out,
    output logic [tlt_pkg::COUNT_WIDTH-1:0]     o_age_out,
    output logic [tlt_pkg::COUNT_WIDTH-1:0]     o_visible_out,
    output logic [tlt_pkg::INV_W-1:0]           o_invisible_out,
    output logic [tlt_pkg::CNT_W-1:0]           o_removed_count,
    output logic [tlt_pkg::CNT_W-1:0]           o_live_count
);
    import tlt_pkg::*;

    t_entry r_mem [MAX_TRACKS];

    logic [RATIO_W-1:0]     r_ratio_min;
    logic [INV_W-1:0]       r_invis_max;
    logic [CNT_W-1:0]       r_occ;
    logic [ID_W-1:0]        r_next_id;
    t_func                  r_func;
    logic [SLOT_W-1:0]      r_slot;
    t_entry                 r_rd_data;
    logic [CNT_W-1:0]       r_rd_idx;
    logic [CNT_W-1:0]       r_kept;
    logic                   r_pend;

    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_status;
    logic [ID_W-1:0]        r_track_id;
    logic [SLOT_W-1:0]      r_slot_out;
    logic [COUNT_WIDTH-1:0] r_age_out;
    logic [COUNT_WIDTH-1:0] r_visible_out;
    logic [INV_W-1:0]       r_invisible_out;
    logic [CNT_W-1:0]       r_removed_count;
    logic [CNT_W-1:0]       r_live_count;

    logic                   sweep_rd;
    logic                   rd_en;
    logic [SLOT_W-1:0]      rd_addr;
    logic                   create_ok;
    logic                   keep;
    logic [2*COUNT_WIDTH-1:0] lhs;
    logic [2*COUNT_WIDTH-1:0] rhs;
    t_entry                 upd_entry;
    t_entry                 new_entry;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    t_entry                 wr_data;

    assign sweep_rd  = i_cmd.sweep_run && (r_rd_idx != r_occ);
    assign rd_en     = i_cmd.rd_slot || sweep_rd;
    assign rd_addr   = i_cmd.rd_slot ? i_slot : r_rd_idx[SLOT_W-1:0];
    assign create_ok = (r_func == FUNC_CREATE) && (r_occ != MAX_TRACKS_C);

    // q1.8 ratio test: visible * 256 >= ratio_min * age
    assign lhs  = (2*COUNT_WIDTH)'({r_rd_data.vis, 8'd0});
    assign rhs  = (2*COUNT_WIDTH)'(r_ratio_min) * (2*COUNT_WIDTH)'(r_rd_data.age);
    assign keep = (lhs >= rhs) && (r_rd_data.inv <= r_invis_max);

    always_comb begin
        upd_entry     = r_rd_data;
        upd_entry.age = (r_rd_data.age == COUNT_MAX) ? COUNT_MAX : r_rd_data.age + 1'b1;
        if (r_func == FUNC_HIT) begin
            upd_entry.vis = (r_rd_data.vis == COUNT_MAX) ? COUNT_MAX
                                                         : r_rd_data.vis + 1'b1;
            upd_entry.inv = '0;
        end else begin
            upd_entry.inv = (r_rd_data.inv == INV_MAX) ? INV_MAX : r_rd_data.inv + 1'b1;
        end
    end

    always_comb begin
        new_entry.id  = r_next_id;
        new_entry.age = COUNT_WIDTH'(1);
        new_entry.vis = COUNT_WIDTH'(1);
        new_entry.inv = '0;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_slot;
        wr_data = upd_entry;
        if (i_cmd.upd_load) begin
            wr_en = 1'b1;
        end else if (i_cmd.fin_load && create_ok) begin
            wr_en   = 1'b1;
            wr_addr = r_occ[SLOT_W-1:0];
            wr_data = new_entry;
        end else if (i_cmd.sweep_run && r_pend && keep) begin
            wr_en   = 1'b1;
            wr_addr = r_kept[SLOT_W-1:0];
            wr_data = r_rd_data;
        end
    end

    // track table
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_min <= RATIO_RESET;
            r_invis_max <= INV_RUN_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_RATIO_MIN: r_ratio_min <= i_cfg_data[RATIO_W-1:0];
                CFG_INVIS_MAX: r_invis_max <= i_cfg_data[INV_W-1:0];
                default:       r_ratio_min <= r_ratio_min;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_func;
            r_slot <= i_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_next_id <= '0;
            r_rd_idx  <= '0;
            r_kept    <= '0;
            r_pend    <= 1'b0;
        end else begin
            if (i_cmd.fin_load && create_ok) begin
                r_occ     <= r_occ + 1'b1;
                r_next_id <= r_next_id + 1'b1;
            end
            if (i_cmd.sweep_start) begin
                r_rd_idx <= '0;
                r_kept   <= '0;
                r_pend   <= 1'b0;
            end else if (i_cmd.sweep_run) begin
                r_pend <= sweep_rd;
                if (sweep_rd) r_rd_idx <= r_rd_idx + 1'b1;
                if (r_pend && keep) r_kept <= r_kept + 1'b1;
            end
            if (i_cmd.sweep_load) r_occ <= r_kept;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.upd_load || i_cmd.fin_load || i_cmd.sweep_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_load) begin
            r_status        <= ST_OK;
            r_track_id      <= upd_entry.id;
            r_slot_out      <= r_slot;
            r_age_out       <= upd_entry.age;
            r_visible_out   <= upd_entry.vis;
            r_invisible_out <= upd_entry.inv;
            r_removed_count <= '0;
            r_live_count    <= r_occ;
        end else if (i_cmd.fin_load) begin
            r_removed_count <= '0;
            if (create_ok) begin
                r_status        <= ST_OK;
                r_track_id      <= new_entry.id;
                r_slot_out      <= r_occ[SLOT_W-1:0];
                r_age_out       <= new_entry.age;
                r_visible_out   <= new_entry.vis;
                r_invisible_out <= new_entry.inv;
                r_live_count    <= r_occ + 1'b1;
            end else begin
                r_status        <= (r_func == FUNC_CREATE) ? ST_FULL : ST_NO_SLOT;
                r_track_id      <= '0;
                r_slot_out      <= '0;
                r_age_out       <= '0;
                r_visible_out   <= '0;
                r_invisible_out <= '0;
                r_live_count    <= r_occ;
            end
        end else if (i_cmd.sweep_load) begin
            r_status        <= ST_OK;
            r_track_id      <= '0;
            r_slot_out      <= '0;
            r_age_out       <= '0;
            r_visible_out   <= '0;
            r_invisible_out <= '0;
            r_removed_count <= r_occ - r_kept;
            r_live_count    <= r_kept;
        end
    end

    assign o_stat.slot_ok    = (CNT_W'(i_slot) < r_occ);
    assign o_stat.out_free   = !r_out_valid || !i_stall;
    assign o_stat.sweep_done = (r_rd_idx == r_occ) && !r_pend;

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_track_id      = r_track_id;
    assign o_slot_out      = r_slot_out;
    assign o_age_out       = r_age_out;
    assign o_visible_out   = r_visible_out;
    assign o_invisible_out = r_invisible_out;
    assign o_removed_count = r_removed_count;
    assign o_live_count    = r_live_count;

endmodule

// File: rtl/core/track_lifecycle_table.sv
// create, hit, miss and error transactions: result registered once the output is free,
// next one taken only after that; hit and miss read then write the table, create writes
// sweep over the live tracks: one table entry read per cycle
// a stalled result holds the block only once the next result is ready to leave
// synchronous active-low reset clears track count, next id and handshake state and
// restores the config defaults; table contents are not cleared
module track_lifecycle_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tlt_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [tlt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_func,
    input  logic [tlt_pkg::SLOT_W-1:0]          i_slot,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [tlt_pkg::STATUS_W-1:0]        o_status,
    output logic [tlt_pkg::ID_W-1:0]            o_track_id,
    output logic [tlt_pkg::SLOT_W-1:0]          o_slot_out,
    output logic [tlt_pkg::COUNT_WIDTH-1:0]     o_age_out,
    output logic [tlt_pkg::COUNT_WIDTH-1:0]     o_visible_out,
    output logic [tlt_pkg::INV_W-1:0]           o_invisible_out,
    output logic [tlt_pkg::CNT_W-1:0]           o_removed_count,
    output logic [tlt_pkg::CNT_W-1:0]           o_live_count
);
    import tlt_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    t_func func;

    assign func = t_func'(i_func);

    tlt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    tlt_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_func          (func),
        .i_slot          (i_slot),
        .i_cmd           (cmd),
        .i_stall         (i_stall),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_track_id      (o_track_id),
        .o_slot_out      (o_slot_out),
        .o_age_out       (o_age_out),
        .o_visible_out   (o_visible_out),
        .o_invisible_out (o_invisible_out),
        .o_removed_count (o_removed_count),
        .o_live_count    (o_live_count)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while previous transaction still in progress");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_live_count <= MAX_TRACKS_C && o_removed_count <= MAX_TRACKS_C))
        else $error("track count out of range");

    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
            (o_track_id == '0 && o_age_out == '0 && o_removed_count == '0))
        else $error("error result carries track data");

endmodule

// File: sim/track_lifecycle_table_test.sv
`timescale 1ns / 100ps

module track_lifecycle_table_test;

    import tlt_pkg::*;

    localparam int  SETTLE_CYCLES = 70;
    localparam real TIMEOUT_NS    = 20_000_000.0;

    typedef struct packed {
        t_status                status;
        logic [ID_W-1:0]        id;
        logic [SLOT_W-1:0]      slot;
        logic [COUNT_WIDTH-1:0] age;
        logic [COUNT_WIDTH-1:0] vis;
        logic [INV_W-1:0]       inv;
        logic [CNT_W-1:0]       removed;
        logic [CNT_W-1:0]       live;
    } t_track_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_stall;
    logic [1:0]             i_func;
    logic [SLOT_W-1:0]      i_slot;
    logic                   o_valid;
    logic                   i_stall;
    logic [STATUS_W-1:0]    o_status;
    logic [ID_W-1:0]        o_track_id;
    logic [SLOT_W-1:0]      o_slot_out;
    logic [COUNT_WIDTH-1:0] o_age_out;
    logic [COUNT_WIDTH-1:0] o_visible_out;
    logic [INV_W-1:0]       o_invisible_out;
    logic [CNT_W-1:0]       o_removed_count;
    logic [CNT_W-1:0]       o_live_count;

    // model of the track table
    t_entry              track_tbl [MAX_TRACKS];
    int                  live_tracks;
    logic [ID_W-1:0]     next_track_id;
    logic [RATIO_W-1:0]  ratio_min;
    logic [INV_W-1:0]    invis_limit;

    t_track_result       pending_results [$];
    int                  error_count;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  stall_hold;

    track_lifecycle_table DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_slot          (i_slot),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_track_id      (o_track_id),
        .o_slot_out      (o_slot_out),
        .o_age_out       (o_age_out),
        .o_visible_out   (o_visible_out),
        .o_invisible_out (o_invisible_out),
        .o_removed_count (o_removed_count),
        .o_live_count    (o_live_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    function automatic t_track_result predict_lifecycle(t_func op, logic [SLOT_W-1:0] slot);
        t_track_result   res;
        int              kept;
        longint unsigned lhs;
        longint unsigned rhs;
        res = '0;
        case (op)
            FUNC_CREATE: begin
                if (live_tracks >= MAX_TRACKS) begin
                    res.status = ST_FULL;
                end else begin
                    track_tbl[live_tracks].id  = next_track_id;
                    track_tbl[live_tracks].age = COUNT_WIDTH'(1);
                    track_tbl[live_tracks].vis = COUNT_WIDTH'(1);
                    track_tbl[live_tracks].inv = '0;
                    res.id   = next_track_id;
                    res.slot = SLOT_W'(live_tracks);
                    res.age  = COUNT_WIDTH'(1);
                    res.vis  = COUNT_WIDTH'(1);
                    next_track_id = next_track_id + 1'b1;
                    live_tracks++;
                end
            end
            FUNC_HIT, FUNC_MISS: begin
                if (slot >= live_tracks) begin
                    res.status = ST_NO_SLOT;
                end else begin
                    if (track_tbl[slot].age != COUNT_MAX) track_tbl[slot].age++;
                    if (op == FUNC_HIT) begin
                        if (track_tbl[slot].vis != COUNT_MAX) track_tbl[slot].vis++;
                        track_tbl[slot].inv = '0;
                    end else if (track_tbl[slot].inv != INV_MAX) begin
                        track_tbl[slot].inv++;
                    end
                    res.id   = track_tbl[slot].id;
                    res.slot = slot;
                    res.age  = track_tbl[slot].age;
                    res.vis  = track_tbl[slot].vis;
                    res.inv  = track_tbl[slot].inv;
                end
            end
            default: begin
                kept = 0;
                for (int i = 0; i < live_tracks; i++) begin
                    lhs = longint'(track_tbl[i].vis) * 256;
                    rhs = longint'(ratio_min) * longint'(track_tbl[i].age);
                    if (lhs >= rhs && track_tbl[i].inv <= invis_limit) begin
                        track_tbl[kept] = track_tbl[i];
                        kept++;
                    end
                end
                res.removed = CNT_W'(live_tracks - kept);
                live_tracks = kept;
            end
        endcase
        res.live = CNT_W'(live_tracks);
        return res;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $error("%s: expected %0d, actual %0d", field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_track_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $error("result transaction with no expectation waiting");
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("track_id", 32'(want.id), 32'(o_track_id));
                check_field("slot_out", 32'(want.slot), 32'(o_slot_out));
                check_field("age_out", 32'(want.age), 32'(o_age_out));
                check_field("visible_out", 32'(want.vis), 32'(o_visible_out));
                check_field("invisible_out", 32'(want.inv), 32'(o_invisible_out));
                check_field("removed_count", 32'(want.removed), 32'(o_removed_count));
                check_field("live_count", 32'(want.live), 32'(o_live_count));
            end
        end
    end

    // receiver side, with a counted hold-off
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_hold > 0) begin
                stall_hold--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic send_op(t_func op, logic [SLOT_W-1:0] slot);
        t_track_result exp_res;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= op;
        i_slot  <= slot;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        exp_res = predict_lifecycle(op, slot);
        pending_results.insert(pending_results.size(), exp_res);
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_addr addr, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (addr == CFG_RATIO_MIN) ratio_min = data[RATIO_W-1:0];
        else invis_limit = data[INV_W-1:0];
    endtask

    // runs on the reset values of both registers
    task automatic test_basic_ops();
        send_op(FUNC_SWEEP, '0);
        send_op(FUNC_HIT, '0);
        send_op(FUNC_MISS, SLOT_W'(63));
        repeat (3) send_op(FUNC_CREATE, '0);
        send_op(FUNC_HIT, '0);
        send_op(FUNC_MISS, SLOT_W'(1));
        send_op(FUNC_MISS, SLOT_W'(1));
        send_op(FUNC_MISS, SLOT_W'(2));
        send_op(FUNC_HIT, SLOT_W'(63));
        send_op(FUNC_MISS, SLOT_W'(3));
        send_op(FUNC_SWEEP, '0);
        send_op(FUNC_HIT, '0);
        send_op(FUNC_SWEEP, '0);
    endtask

    task automatic test_table_full();
        wait_results_done();
        cfg_write(CFG_RATIO_MIN, '0);
        cfg_write(CFG_INVIS_MAX, CFG_DATA_W'(255));
        while (live_tracks < MAX_TRACKS) send_op(FUNC_CREATE, '0);
        send_op(FUNC_CREATE, '0);
        send_op(FUNC_CREATE, SLOT_W'(63));
        send_op(FUNC_HIT, SLOT_W'(63));
        send_op(FUNC_MISS, SLOT_W'(63));
        send_op(FUNC_SWEEP, '0);
        // ratio above 1.0 drops every track
        wait_results_done();
        cfg_write(CFG_RATIO_MIN, CFG_DATA_W'(511));
        send_op(FUNC_SWEEP, '0);
        send_op(FUNC_SWEEP, '0);
    endtask

    task automatic test_invisible_saturation();
        wait_results_done();
        cfg_write(CFG_RATIO_MIN, '0);
        cfg_write(CFG_INVIS_MAX, CFG_DATA_W'(255));
        send_op(FUNC_CREATE, '0);
        repeat (258) send_op(FUNC_MISS, SLOT_W'(live_tracks - 1));
        send_op(FUNC_SWEEP, '0);
        wait_results_done();
        cfg_write(CFG_INVIS_MAX, CFG_DATA_W'(254));
        send_op(FUNC_SWEEP, '0);
    endtask

    task automatic test_backpressure();
        wait_results_done();
        cfg_write(CFG_RATIO_MIN, CFG_DATA_W'(128));
        cfg_write(CFG_INVIS_MAX, CFG_DATA_W'(3));
        stall_hold = 200;
        repeat (8) send_op(FUNC_CREATE, '0);
        repeat (12) send_op(FUNC_HIT, SLOT_W'($urandom_range(live_tracks - 1)));
        send_op(FUNC_SWEEP, '0);
        wait_results_done();
    endtask

    task automatic test_full_ratio();
        wait_results_done();
        cfg_write(CFG_RATIO_MIN, CFG_DATA_W'(511));
        send_op(FUNC_SWEEP, '0);
        wait_results_done();
        cfg_write(CFG_RATIO_MIN, CFG_DATA_W'(256));
        cfg_write(CFG_INVIS_MAX, '0);
        send_op(FUNC_CREATE, '0);
        repeat (20) send_op(FUNC_HIT, '0);
        send_op(FUNC_MISS, '0);
        send_op(FUNC_SWEEP, '0);
        send_op(FUNC_HIT, '0);
        send_op(FUNC_SWEEP, '0);
    endtask

    task automatic test_random_traffic(int n_items);
        int r;
        logic [CFG_DATA_W-1:0] ratio_val;
        logic [CFG_DATA_W-1:0] invis_val;
        for (int blk = 0; blk < 5; blk++) begin
            wait_results_done();
            case ($urandom_range(4))
                0:       ratio_val = '0;
                1:       ratio_val = CFG_DATA_W'(256);
                2:       ratio_val = CFG_DATA_W'(511);
                default: ratio_val = CFG_DATA_W'($urandom_range(256));
            endcase
            case ($urandom_range(3))
                0:       invis_val = '0;
                1:       invis_val = CFG_DATA_W'(255);
                default: invis_val = CFG_DATA_W'($urandom_range(6));
            endcase
            cfg_write(CFG_RATIO_MIN, ratio_val);
            cfg_write(CFG_INVIS_MAX, invis_val);
            for (int k = 0; k < n_items / 5; k++) begin
                r = $urandom_range(99);
                if (r < 30)
                    send_op(FUNC_CREATE, SLOT_W'($urandom_range(63)));
                else if (r < 58 && live_tracks > 0)
                    send_op(FUNC_HIT, SLOT_W'($urandom_range(live_tracks - 1)));
                else if (r < 82 && live_tracks > 0)
                    send_op(FUNC_MISS, SLOT_W'($urandom_range(live_tracks - 1)));
                else if (r < 90)
                    send_op(FUNC_SWEEP, SLOT_W'($urandom_range(63)));
                else if (r < 95 && live_tracks < MAX_TRACKS)
                    send_op(t_func'($urandom_range(1, 2)),
                            SLOT_W'($urandom_range(63, live_tracks)));
                else
                    send_op(t_func'($urandom_range(3)), SLOT_W'($urandom_range(63)));
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_RATIO_MIN;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_func        = FUNC_CREATE;
        i_slot        = '0;
        live_tracks   = 0;
        next_track_id = '0;
        ratio_min     = RATIO_RESET;
        invis_limit   = INV_RUN_RESET;
        error_count   = 0;
        stall_hold    = 0;
        send_idle_pct = 28;
        recv_idle_pct = 55;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_table_full();
        test_invisible_saturation();
        test_backpressure();
        test_random_traffic(125);

        send_idle_pct = 55;
        recv_idle_pct = 28;
        test_random_traffic(125);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_ratio();
        test_random_traffic(125);

        wait_results_done();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
